// ===== design/tpt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tpt_pkg
// Shared types, sizes and tables for the TLB / page-table translator.
// ----------------------------------------------------------------------------
package tpt_pkg;

  localparam int TLB_ENTRIES = 16;
  localparam int PAGE_COUNT  = 256;
  localparam int FRAME_BYTES = 256;

  localparam int ADDR_W     = 16;
  localparam int BYTE_W     = 8;
  localparam int COUNT_W    = 32;
  localparam int FREE_W     = 9;
  localparam int PIDX_W     = $clog2(PAGE_COUNT);
  localparam int TLB_IDX_W  = $clog2(TLB_ENTRIES);
  localparam int PAGE_SPAN  = 1 << BYTE_W;

  typedef logic [PIDX_W-1:0] pidx_lut_t [PAGE_SPAN];

  // page number to table index (page modulo table size), built at elaboration
  function automatic pidx_lut_t build_pidx_lut();
    pidx_lut_t lut;
    for (int i = 0; i < PAGE_SPAN; i++) begin
      lut[i] = PIDX_W'(i % PAGE_COUNT);
    end
    return lut;
  endfunction

  localparam pidx_lut_t PIDX_LUT = build_pidx_lut();

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_PT_READ
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;         // capture the incoming address
    logic pt_read;      // read the page-table RAM
    logic finish_hit;   // retire a TLB hit
    logic finish_fault; // retire a page fault (map new frame)
    logic finish_read;  // retire a mapped miss from RAM data
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hit;
    logic mapped;
    logic out_free;
  } status_t;

endpackage : tpt_pkg
`default_nettype wire

// ===== design/tpt_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tpt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule : tpt_ram
`default_nettype wire

// ===== design/tpt_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tpt_ctrl
// Sequencer: accept, TLB lookup, optional page-table read, retire.
// ----------------------------------------------------------------------------
module tpt_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire tpt_pkg::status_t status_i,
  output tpt_pkg::cmd_t         cmd_o
);
  import tpt_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (status_i.hit) begin
          if (status_i.out_free) begin
            cmd_o.finish_hit = 1'b1;
            state_d          = ST_IDLE;
          end
        end else if (!status_i.mapped) begin
          if (status_i.out_free) begin
            cmd_o.finish_fault = 1'b1;
            state_d            = ST_IDLE;
          end
        end else begin
          cmd_o.pt_read = 1'b1;
          state_d       = ST_PT_READ;
        end
      end
      ST_PT_READ: begin
        // RAM data holds while the output slot is busy
        if (status_i.out_free) begin
          cmd_o.finish_read = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule : tpt_ctrl
`default_nettype wire

// ===== design/tpt_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tpt_datapath
// TLB entries, page-table valid bits and RAM, frame allocator, counters and
// the output register.
// ----------------------------------------------------------------------------
module tpt_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire tpt_pkg::cmd_t                 cmd_i,
  output tpt_pkg::status_t                   status_o,
  input  wire logic [tpt_pkg::ADDR_W-1:0]    logical_address_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [tpt_pkg::ADDR_W-1:0]    physical_address_o,
  output logic      [tpt_pkg::BYTE_W-1:0]    page_number_o,
  output logic      [tpt_pkg::BYTE_W-1:0]    frame_number_o,
  output logic                               tlb_hit_o,
  output logic                               page_fault_o,
  output logic      [tpt_pkg::COUNT_W-1:0]   hit_count_o,
  output logic      [tpt_pkg::COUNT_W-1:0]   fault_count_o
);
  import tpt_pkg::*;

  // current item
  logic [ADDR_W-1:0]    addr_q;
  logic [PIDX_W-1:0]    pidx_q;

  // TLB
  logic [PIDX_W-1:0]    tlb_tag_q   [TLB_ENTRIES];
  logic [BYTE_W-1:0]    tlb_frame_q [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] tlb_valid_q;
  logic [TLB_IDX_W-1:0] ptr_q;

  // page table bookkeeping
  logic [PAGE_COUNT-1:0] page_valid_q;
  logic [FREE_W-1:0]     next_free_q;
  logic [COUNT_W-1:0]    hits_q, faults_q;

  // output register
  logic                  out_valid_q;
  logic [ADDR_W-1:0]     out_phys_q;
  logic [BYTE_W-1:0]     out_page_q, out_frame_q;
  logic                  out_hit_q, out_fault_q;

  logic                  hit;
  logic [BYTE_W-1:0]     hit_frame;
  logic [BYTE_W-1:0]     ram_rdata;
  logic [BYTE_W-1:0]     new_frame;
  logic [BYTE_W-1:0]     res_frame;
  logic                  finish;
  logic                  tlb_fill;

  // fully associative match; the highest matching index wins
  always_comb begin
    hit       = 1'b0;
    hit_frame = '0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      if (tlb_valid_q[i] && (tlb_tag_q[i] == pidx_q)) begin
        hit       = 1'b1;
        hit_frame = tlb_frame_q[i];
      end
    end
  end

  assign new_frame = next_free_q[BYTE_W-1:0];
  assign tlb_fill  = cmd_i.finish_fault | cmd_i.finish_read;
  assign finish    = cmd_i.finish_hit | tlb_fill;

  always_comb begin
    res_frame = ram_rdata;
    if (cmd_i.finish_hit) begin
      res_frame = hit_frame;
    end else if (cmd_i.finish_fault) begin
      res_frame = new_frame;
    end
  end

  assign status_o.hit      = hit;
  assign status_o.mapped   = page_valid_q[pidx_q];
  assign status_o.out_free = !out_valid_q || out_ready_i;

  tpt_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (PAGE_COUNT)
  ) u_page_table (
    .clk_i   (clk_i),
    .we_i    (cmd_i.finish_fault),
    .waddr_i (pidx_q),
    .wdata_i (new_frame),
    .re_i    (cmd_i.pt_read),
    .raddr_i (pidx_q),
    .rdata_o (ram_rdata)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tlb_valid_q  <= '0;
      ptr_q        <= '0;
      page_valid_q <= '0;
      next_free_q  <= '0;
      hits_q       <= '0;
      faults_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.finish_hit && (hits_q != '1)) begin
        hits_q <= hits_q + COUNT_W'(1);
      end
      if (cmd_i.finish_fault) begin
        page_valid_q[pidx_q] <= 1'b1;
        next_free_q          <= next_free_q + FREE_W'(1);
        if (faults_q != '1) begin
          faults_q <= faults_q + COUNT_W'(1);
        end
      end
      if (tlb_fill) begin
        tlb_valid_q[ptr_q] <= 1'b1;
        ptr_q <= (ptr_q == TLB_IDX_W'(TLB_ENTRIES - 1)) ? '0 : ptr_q + TLB_IDX_W'(1);
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      addr_q <= logical_address_i;
      pidx_q <= PIDX_LUT[logical_address_i[ADDR_W-1:BYTE_W]];
    end
    if (tlb_fill) begin
      tlb_tag_q[ptr_q]   <= pidx_q;
      tlb_frame_q[ptr_q] <= res_frame;
    end
    if (finish) begin
      out_phys_q  <= ADDR_W'(32'(res_frame) * FRAME_BYTES + 32'(addr_q[BYTE_W-1:0]));
      out_page_q  <= addr_q[ADDR_W-1:BYTE_W];
      out_frame_q <= res_frame;
      out_hit_q   <= cmd_i.finish_hit;
      out_fault_q <= cmd_i.finish_fault;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign physical_address_o = out_phys_q;
  assign page_number_o      = out_page_q;
  assign frame_number_o     = out_frame_q;
  assign tlb_hit_o          = out_hit_q;
  assign page_fault_o       = out_fault_q;
  assign hit_count_o        = hits_q;
  assign fault_count_o      = faults_q;

endmodule : tpt_datapath
`default_nettype wire

// ===== design/tlb_page_table_translator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tlb_page_table_translator
// Logical to physical address translation: 16-entry TLB with FIFO
// replacement backed by a 256-entry page table with demand frame allocation.
// ----------------------------------------------------------------------------
//  channel   handshake                  payload
//  input     in_valid_i / in_ready_o    logical_address_i
//  output    out_valid_o / out_ready_i  physical_address_o, page_number_o,
//                                       frame_number_o, tlb_hit_o,
//                                       page_fault_o, hit_count_o,
//                                       fault_count_o
//
//  One item at a time: a TLB hit or page fault retires from the lookup state
//  after accept; a miss on a mapped page adds a page-table RAM read state.
//  The one-entry output register lets the next transfer be accepted while a
//  result waits; retirement stalls only while that register is still full.
//  Reset clears TLB and page valid bits, pointer, frame allocator, counters.
// ----------------------------------------------------------------------------
module tlb_page_table_translator (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [tpt_pkg::ADDR_W-1:0]    logical_address_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [tpt_pkg::ADDR_W-1:0]    physical_address_o,
  output logic      [tpt_pkg::BYTE_W-1:0]    page_number_o,
  output logic      [tpt_pkg::BYTE_W-1:0]    frame_number_o,
  output logic                               tlb_hit_o,
  output logic                               page_fault_o,
  output logic      [tpt_pkg::COUNT_W-1:0]   hit_count_o,
  output logic      [tpt_pkg::COUNT_W-1:0]   fault_count_o
);
  import tpt_pkg::*;

  cmd_t    cmd;
  status_t status;

  tpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tpt_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .logical_address_i  (logical_address_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .physical_address_o (physical_address_o),
    .page_number_o      (page_number_o),
    .frame_number_o     (frame_number_o),
    .tlb_hit_o          (tlb_hit_o),
    .page_fault_o       (page_fault_o),
    .hit_count_o        (hit_count_o),
    .fault_count_o      (fault_count_o)
  );

endmodule : tlb_page_table_translator
`default_nettype wire

// ===== sim/tb_tlb_page_table_translator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tlb_page_table_translator
// Self-checking bench for the TLB / page-table translator. A short directed
// table covers page 255 after reset, TLB wrap and eviction, and mapped
// misses. A random mix of hot pages and fresh pages follows, along with a
// full sweep of the page space. Each result is compared field by field with
// a typed-in value or an in-bench translation model, under several idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_tlb_page_table_translator;
  import tpt_pkg::*;

  typedef struct packed {
    logic [ADDR_W-1:0]  phys;
    logic [BYTE_W-1:0]  page;
    logic [BYTE_W-1:0]  frame;
    logic               hit;
    logic               fault;
    logic [COUNT_W-1:0] hits;
    logic [COUNT_W-1:0] faults;
  } xlat_result_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              fixed;  // expected result typed in below
    xlat_result_t      want;
  } vector_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [ADDR_W-1:0] logical_address = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ADDR_W-1:0]  physical_address;
  logic [BYTE_W-1:0]  page_number;
  logic [BYTE_W-1:0]  frame_number;
  logic               tlb_hit;
  logic               page_fault;
  logic [COUNT_W-1:0] hit_count;
  logic [COUNT_W-1:0] fault_count;

  // translation model state
  logic [BYTE_W-1:0]  tlb_tag_m   [TLB_ENTRIES];
  logic [BYTE_W-1:0]  tlb_frame_m [TLB_ENTRIES];
  bit                 tlb_vld_m   [TLB_ENTRIES];
  int unsigned        fifo_ptr = 0;
  logic [BYTE_W-1:0]  pt_frame_m  [PAGE_COUNT];
  bit                 pt_vld_m    [PAGE_COUNT];
  logic [FREE_W-1:0]  free_frame = '0;
  logic [COUNT_W-1:0] hit_total = '0;
  logic [COUNT_W-1:0] fault_total = '0;

  xlat_result_t pending_xlat [$];
  logic [BYTE_W-1:0] recent_pages [$];
  int unsigned fail_count = 0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;

  vector_t dir_vectors [] = '{
    '{16'hFFFF, 1'b1, '{16'h00FF, 8'hFF, 8'h00, 1'b0, 1'b1, 32'd0, 32'd1}},
    '{16'hFF00, 1'b1, '{16'h0000, 8'hFF, 8'h00, 1'b1, 1'b0, 32'd1, 32'd1}},
    '{16'h0000, 1'b1, '{16'h0100, 8'h00, 8'h01, 1'b0, 1'b1, 32'd1, 32'd2}},
    '{16'h00FF, 1'b1, '{16'h01FF, 8'h00, 8'h01, 1'b1, 1'b0, 32'd2, 32'd2}},
    '{16'h01A5, 1'b0, '0}, '{16'h025A, 1'b0, '0}, '{16'h0301, 1'b0, '0},
    '{16'h04FE, 1'b0, '0}, '{16'h0580, 1'b0, '0}, '{16'h067F, 1'b0, '0},
    '{16'h0733, 1'b0, '0}, '{16'h08CC, 1'b0, '0}, '{16'h0955, 1'b0, '0},
    '{16'h0AAA, 1'b0, '0}, '{16'h0B0F, 1'b0, '0}, '{16'h0CF0, 1'b0, '0},
    '{16'h0D11, 1'b0, '0}, '{16'h0EEE, 1'b0, '0},
    // TLB full; pointer wrapped, page 0x80 evicts page 255
    '{16'h8042, 1'b0, '0},
    // page 255 mapped but out of the TLB: table read, no fault
    '{16'hFF7F, 1'b1, '{16'h007F, 8'hFF, 8'h00, 1'b0, 1'b0, 32'd2, 32'd17}},
    '{16'h00AA, 1'b1, '{16'h01AA, 8'h00, 8'h01, 1'b0, 1'b0, 32'd2, 32'd17}},
    '{16'hFF80, 1'b1, '{16'h0080, 8'hFF, 8'h00, 1'b1, 1'b0, 32'd3, 32'd17}},
    '{16'h0155, 1'b0, '0}
  };

  tlb_page_table_translator DUT (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .logical_address_i  (logical_address),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .physical_address_o (physical_address),
    .page_number_o      (page_number),
    .frame_number_o     (frame_number),
    .tlb_hit_o          (tlb_hit),
    .page_fault_o       (page_fault),
    .hit_count_o        (hit_count),
    .fault_count_o      (fault_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // advance the translation state by one address and return its result
  function automatic xlat_result_t translate(input logic [ADDR_W-1:0] addr);
    xlat_result_t res;
    int unsigned pidx;
    logic [BYTE_W-1:0] frame;
    bit hit;
    bit fault;
    pidx  = addr[15:8] % PAGE_COUNT;
    frame = '0;
    hit   = 1'b0;
    fault = 1'b0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      if (tlb_vld_m[i] && tlb_tag_m[i] == BYTE_W'(pidx)) begin
        frame = tlb_frame_m[i];
        hit   = 1'b1;
      end
    end
    if (hit) begin
      if (hit_total != '1) hit_total++;
    end else begin
      if (!pt_vld_m[pidx]) begin
        pt_frame_m[pidx] = free_frame[BYTE_W-1:0];
        pt_vld_m[pidx]   = 1'b1;
        free_frame++;
        if (fault_total != '1) fault_total++;
        fault = 1'b1;
      end
      frame = pt_frame_m[pidx];
      tlb_tag_m[fifo_ptr]   = BYTE_W'(pidx);
      tlb_frame_m[fifo_ptr] = frame;
      tlb_vld_m[fifo_ptr]   = 1'b1;
      fifo_ptr = (fifo_ptr + 1) % TLB_ENTRIES;
    end
    res.phys   = ADDR_W'(32'(frame) * FRAME_BYTES + 32'(addr[7:0]));
    res.page   = addr[15:8];
    res.frame  = frame;
    res.hit    = hit;
    res.fault  = fault;
    res.hits   = hit_total;
    res.faults = fault_total;
    return res;
  endfunction

  // one input transfer; valid stays high afterward unless the next call idles
  task automatic send_addr(input logic [ADDR_W-1:0] addr, input logic fixed,
                           input xlat_result_t want);
    xlat_result_t res;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    logical_address <= addr;
    do @(posedge clk); while (!in_ready);
    res = translate(addr);
    pending_xlat.push_back(fixed ? want : res);
  endtask

  task automatic drain();
    while (pending_xlat.size() != 0) @(posedge clk);
  endtask

  task automatic send_random(input int unsigned count);
    logic [BYTE_W-1:0] page;
    for (int n = 0; n < count; n++) begin
      // half hot pages (hits and mapped misses), half anywhere
      if ($urandom_range(99) < 50 && recent_pages.size() != 0)
        page = recent_pages[$urandom_range(recent_pages.size() - 1)];
      else
        page = BYTE_W'($urandom_range(255));
      recent_pages.push_back(page);
      if (recent_pages.size() > 32) void'(recent_pages.pop_front());
      send_addr({page, BYTE_W'($urandom_range(255))}, 1'b0, '0);
    end
  endtask

  task automatic cmp_field(input string name, input logic [31:0] want,
                           input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk) begin
    xlat_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_xlat.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual phys %h",
                 $time, physical_address);
        fail_count++;
      end else begin
        want = pending_xlat.pop_front();
        cmp_field("physical_address", 32'(want.phys), 32'(physical_address));
        cmp_field("page_number", 32'(want.page), 32'(page_number));
        cmp_field("frame_number", 32'(want.frame), 32'(frame_number));
        cmp_field("tlb_hit", 32'(want.hit), 32'(tlb_hit));
        cmp_field("page_fault", 32'(want.fault), 32'(page_fault));
        cmp_field("hit_count", want.hits, hit_count);
        cmp_field("fault_count", want.faults, fault_count);
      end
    end
  end

  initial begin
    for (int i = 0; i < TLB_ENTRIES; i++) tlb_vld_m[i] = 1'b0;
    for (int i = 0; i < PAGE_COUNT; i++) pt_vld_m[i] = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_vectors[i])
      send_addr(dir_vectors[i].addr, dir_vectors[i].fixed, dir_vectors[i].want);

    send_random(150);

    // hold off until every result is back
    in_valid <= 1'b0;
    drain();

    // sweep the whole page space so the allocator hands out every frame
    src_idle_pct = 73;
    for (int p = 0; p < 256; p++)
      send_addr({BYTE_W'(p), BYTE_W'($urandom_range(255))}, 1'b0, '0);

    src_idle_pct  = 0;
    snk_stall_pct = 73;
    send_random(100);

    src_idle_pct  = 24;
    snk_stall_pct = 24;
    send_random(100);

    in_valid <= 1'b0;
    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("status: fail");
    $finish;
  end

endmodule
